### design/tchebycheff_neighbour_update_macros.svh
// assertion macros for the neighbourhood update block
`ifndef TCHEBYCHEFF_NEIGHBOUR_UPDATE_MACROS_SVH
`define TCHEBYCHEFF_NEIGHBOUR_UPDATE_MACROS_SVH

// same-cycle implication or plain property
`define TNU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// next-cycle implication
`define TNU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

### design/tnu_pkg.sv
// shared constants and codes of the neighbourhood update block
`timescale 1ns / 1ps
package tnu_pkg;
    localparam int N_SUB_DEF    = 64;
    localparam int NEIGH_DEF    = 6;
    localparam int OBJ_W        = 32;
    localparam int TAG_W        = 32;
    localparam int WGT_W        = 17;
    localparam int PROD_W       = OBJ_W + WGT_W;
    localparam int IDX_W        = 6;
    localparam int OP_W         = 2;
    localparam int CNT_W        = 3;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_OFFER = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;
endpackage

### design/tnu_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface tnu_in_if import tnu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  index;
    logic [OBJ_W-1:0]  obj_nodes;
    logic [OBJ_W-1:0]  obj_energy;
    logic [TAG_W-1:0]  solution_tag;
    modport source (output valid, op, index, obj_nodes, obj_energy, solution_tag,
                    input ready);
    modport sink   (input valid, op, index, obj_nodes, obj_energy, solution_tag,
                    output ready);
endinterface

interface tnu_out_if import tnu_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   done_op;
    logic [CNT_W-1:0]  replaced_count;
    logic [OBJ_W-1:0]  ref_nodes;
    logic [OBJ_W-1:0]  ref_energy;
    logic [OBJ_W-1:0]  read_nodes;
    logic [OBJ_W-1:0]  read_energy;
    logic [TAG_W-1:0]  read_tag;
    modport source (output valid, done_op, replaced_count, ref_nodes, ref_energy,
                    read_nodes, read_energy, read_tag, input ready);
    modport sink   (input valid, done_op, replaced_count, ref_nodes, ref_energy,
                    read_nodes, read_energy, read_tag, output ready);
endinterface

### design/tnu_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module tnu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### design/tnu_tables.sv
// constant neighbour lists and subproblem weights
`timescale 1ns / 1ps
module tnu_tables import tnu_pkg::*; #(
    parameter int N_SUB    = N_SUB_DEF,
    parameter int NEFF     = NEIGH_DEF,
    parameter int AW       = $clog2(N_SUB),
    parameter int SW       = 3
) (
    input  logic [AW-1:0]    i_row,
    input  logic [SW-1:0]    i_slot,
    input  logic [AW-1:0]    i_k,
    output logic [AW-1:0]    o_nbr,
    output logic [WGT_W-1:0] o_w0,
    output logic [WGT_W-1:0] o_w1
);
    function automatic int nbr_calc(int row, int slot);
        int gap  [N_SUB];
        int idx  [N_SUB];
        int td;
        int ti;
        for (int j = 0; j < N_SUB; j++) begin
            gap[j] = (row >= j) ? (row - j) : (j - row);
            idx[j] = j;
        end
        for (int a = 0; a <= slot; a++) begin
            for (int b = a + 1; b < N_SUB; b++) begin
                if (gap[a] > gap[b]) begin
                    td     = gap[a];
                    ti     = idx[a];
                    gap[a] = gap[b];
                    gap[b] = td;
                    idx[a] = idx[b];
                    idx[b] = ti;
                end
            end
        end
        return idx[slot];
    endfunction

    function automatic int w_calc(int num);
        longint q;
        q = (longint'(num) <<< 16) / (N_SUB - 1);
        if (q == 0) begin
            q = 1;
        end
        return int'(q);
    endfunction

    logic [AW-1:0]    nbr_tab [N_SUB][NEFF];
    logic [WGT_W-1:0] w0_tab  [N_SUB];
    logic [WGT_W-1:0] w1_tab  [N_SUB];

    for (genvar gi = 0; gi < N_SUB; gi++) begin : g_row
        assign w0_tab[gi] = WGT_W'(w_calc(gi));
        assign w1_tab[gi] = WGT_W'(w_calc(N_SUB - 1 - gi));
        for (genvar ga = 0; ga < NEFF; ga++) begin : g_slot
            assign nbr_tab[gi][ga] = AW'(nbr_calc(gi, ga));
        end
    end

    assign o_nbr = nbr_tab[i_row][i_slot];
    assign o_w0  = w0_tab[i_k];
    assign o_w1  = w1_tab[i_k];
endmodule

### design/tchebycheff_neighbour_update.sv
// top level of the tchebycheff neighbourhood update block
`timescale 1ns / 1ps
// Two-objective decomposition store: one entry (two Q16.16 objectives and a
// tag) per subproblem in a single ram with registered read. A write goes to
// the ram as it is taken, a read through S_RDWAIT; each ends in S_FIN. An
// offer lowers the reference point, then walks the neighbour list one entry
// at a time: read, multiply the stored entry, multiply the child, compare and
// write back (S_NREAD, S_MOLD, S_MNEW, S_CMP) through one shared pair of
// 32x17 multipliers. One request is handled at a time; a new request is taken
// while the previous result still waits.
module tchebycheff_neighbour_update import tnu_pkg::*; #(
    parameter int N_SUB    = N_SUB_DEF,
    parameter int NEIGH    = NEIGH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tnu_in_if.sink    i_req,
    tnu_out_if.source o_rsp
);
    localparam int NEFF = (NEIGH < N_SUB) ? NEIGH : N_SUB;
    localparam int AW   = $clog2(N_SUB);
    localparam int SW   = (NEFF > 1) ? $clog2(NEFF) : 1;
    localparam int EW   = 2 * OBJ_W + TAG_W;

    typedef enum logic [2:0] {
        S_IDLE, S_RDWAIT, S_NREAD, S_MOLD, S_MNEW, S_CMP, S_FIN
    } t_state;

    t_state             r_state;
    logic [OBJ_W-1:0]   r_ref_n, r_ref_e;
    logic [OP_W-1:0]    r_op;
    logic [AW-1:0]      r_addr;
    logic [OBJ_W-1:0]   r_yn, r_ye;
    logic [TAG_W-1:0]   r_tag;
    logic [SW-1:0]      r_slot;
    logic [AW-1:0]      r_k;
    logic [CNT_W-1:0]   r_cnt;
    logic [PROD_W-1:0]  r_p0, r_p1, r_sold;
    logic [EW-1:0]      r_rd;
    logic               r_ovalid;
    logic [OP_W-1:0]    r_o_op;
    logic [CNT_W-1:0]   r_o_cnt;
    logic [OBJ_W-1:0]   r_o_ref_n, r_o_ref_e;
    logic [EW-1:0]      r_o_rd;

    logic               acc;
    logic               in_range;
    logic [AW-1:0]      req_addr;
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [EW-1:0]      ram_wdata, ram_rdata;
    logic [AW-1:0]      nbr;
    logic [WGT_W-1:0]   w0, w1;
    logic [OBJ_W-1:0]   mul_a0, mul_a1, d_n, d_e;
    logic [PROD_W-1:0]  prod0, prod1, smax;
    logic               last_slot;

    assign acc      = i_req.valid && i_req.ready;
    assign req_addr = AW'(i_req.index);
    assign in_range = ({26'd0, i_req.index} < 32'(N_SUB));
    assign i_req.ready = (r_state == S_IDLE);
    assign last_slot = (r_slot == SW'(NEFF - 1));

    tnu_ram #(.WIDTH(EW), .DEPTH(N_SUB)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tnu_tables #(.N_SUB(N_SUB), .NEFF(NEFF), .AW(AW), .SW(SW)) u_tab (
        .i_row  (r_addr),
        .i_slot (r_slot),
        .i_k    (r_k),
        .o_nbr  (nbr),
        .o_w0   (w0),
        .o_w1   (w1)
    );

    // operands of the shared multipliers: stored entry first, then the child
    always_comb begin
        if (r_state == S_MOLD) begin
            mul_a0 = ram_rdata[EW-1 -: OBJ_W];
            mul_a1 = ram_rdata[EW-OBJ_W-1 -: OBJ_W];
        end else begin
            mul_a0 = r_yn;
            mul_a1 = r_ye;
        end
        d_n   = (mul_a0 >= r_ref_n) ? (mul_a0 - r_ref_n) : (r_ref_n - mul_a0);
        d_e   = (mul_a1 >= r_ref_e) ? (mul_a1 - r_ref_e) : (r_ref_e - mul_a1);
        prod0 = PROD_W'(d_n) * PROD_W'(w0);
        prod1 = PROD_W'(d_e) * PROD_W'(w1);
        smax  = (r_p0 > r_p1) ? r_p0 : r_p1;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = req_addr;
        ram_wdata = {i_req.obj_nodes, i_req.obj_energy, i_req.solution_tag};
        ram_re    = 1'b0;
        ram_raddr = req_addr;
        unique case (r_state)
            S_IDLE: begin
                ram_we = acc && in_range && (i_req.op == OP_WRITE);
                ram_re = acc && (i_req.op == OP_READ);
            end
            S_NREAD: begin
                ram_re    = 1'b1;
                ram_raddr = nbr;
            end
            S_CMP: begin
                ram_we    = (smax < r_sold);
                ram_waddr = r_k;
                ram_wdata = {r_yn, r_ye, r_tag};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ref_n  <= '1;
            r_ref_e  <= '1;
            r_ovalid <= 1'b0;
        end else begin
            if (o_rsp.ready && r_state != S_FIN) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_op   <= i_req.op;
                        r_addr <= req_addr;
                        r_yn   <= i_req.obj_nodes;
                        r_ye   <= i_req.obj_energy;
                        r_tag  <= i_req.solution_tag;
                        r_cnt  <= '0;
                        r_slot <= '0;
                        r_rd   <= '0;
                        if (i_req.op == OP_OFFER) begin
                            if (i_req.obj_nodes < r_ref_n) begin
                                r_ref_n <= i_req.obj_nodes;
                            end
                            if (i_req.obj_energy < r_ref_e) begin
                                r_ref_e <= i_req.obj_energy;
                            end
                            r_state <= in_range ? S_NREAD : S_FIN;
                        end else if (i_req.op == OP_READ && in_range) begin
                            r_state <= S_RDWAIT;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_RDWAIT: begin
                    r_rd    <= ram_rdata;
                    r_state <= S_FIN;
                end
                S_NREAD: begin
                    r_k     <= nbr;
                    r_state <= S_MOLD;
                end
                S_MOLD: begin
                    r_p0    <= prod0;
                    r_p1    <= prod1;
                    r_state <= S_MNEW;
                end
                S_MNEW: begin
                    r_sold  <= smax;
                    r_p0    <= prod0;
                    r_p1    <= prod1;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (smax < r_sold && r_cnt != '1) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    if (last_slot) begin
                        r_state <= S_FIN;
                    end else begin
                        r_slot  <= r_slot + SW'(1);
                        r_state <= S_NREAD;
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid  <= 1'b1;
                        r_o_op    <= r_op;
                        r_o_cnt   <= r_cnt;
                        r_o_ref_n <= r_ref_n;
                        r_o_ref_e <= r_ref_e;
                        r_o_rd    <= r_rd;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.done_op        = r_o_op;
    assign o_rsp.replaced_count = r_o_cnt;
    assign o_rsp.ref_nodes      = r_o_ref_n;
    assign o_rsp.ref_energy     = r_o_ref_e;
    assign o_rsp.read_nodes     = r_o_rd[EW-1 -: OBJ_W];
    assign o_rsp.read_energy    = r_o_rd[EW-OBJ_W-1 -: OBJ_W];
    assign o_rsp.read_tag       = r_o_rd[TAG_W-1:0];
endmodule

### design/tnu_checker.sv
// port-level checker for the neighbourhood update block, with its bind
`timescale 1ns / 1ps
`include "tchebycheff_neighbour_update_macros.svh"
module tnu_port_checker import tnu_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             i_ready,
    input logic [OP_W-1:0]  i_done_op,
    input logic [CNT_W-1:0] i_replaced_count,
    input logic [OBJ_W-1:0] i_ref_nodes,
    input logic [OBJ_W-1:0] i_ref_energy,
    input logic [OBJ_W-1:0] i_read_nodes,
    input logic [OBJ_W-1:0] i_read_energy,
    input logic [TAG_W-1:0] i_read_tag
);
    logic             r_seen;
    logic [OBJ_W-1:0] r_last_n, r_last_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (i_valid && i_ready) begin
            r_seen   <= 1'b1;
            r_last_n <= i_ref_nodes;
            r_last_e <= i_ref_energy;
        end
    end

    `TNU_ASSERT(a_cnt_offer_only, i_clk, i_rst_n, (i_valid && i_done_op != OP_OFFER) |-> (i_replaced_count == 3'd0), "replaced count on non-offer")
    `TNU_ASSERT(a_read_zero, i_clk, i_rst_n, (i_valid && i_done_op != OP_READ) |-> (i_read_nodes == 32'd0 && i_read_energy == 32'd0 && i_read_tag == 32'd0), "read fields set on non-read")
    `TNU_ASSERT(a_ref_monotone, i_clk, i_rst_n, (i_valid && i_ready && r_seen) |-> (i_ref_nodes <= r_last_n && i_ref_energy <= r_last_e), "reference point rose")
    `TNU_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, (i_valid && !i_ready), (i_valid && $stable(i_done_op) && $stable(i_ref_nodes)), "stalled response changed")
endmodule

bind tchebycheff_neighbour_update tnu_port_checker u_tnu_port_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_rsp.valid),
    .i_ready          (o_rsp.ready),
    .i_done_op        (o_rsp.done_op),
    .i_replaced_count (o_rsp.replaced_count),
    .i_ref_nodes      (o_rsp.ref_nodes),
    .i_ref_energy     (o_rsp.ref_energy),
    .i_read_nodes     (o_rsp.read_nodes),
    .i_read_energy    (o_rsp.read_energy),
    .i_read_tag       (o_rsp.read_tag)
);

### dv/tnu_checker.sv
// request watcher, subproblem store predictor and response checker
`timescale 1ns / 1ps
module tnu_checker import tnu_pkg::*; #(
    parameter int N_SUB    = N_SUB_DEF,
    parameter int NEIGH    = NEIGH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tnu_in_if          i_req,
    tnu_out_if         i_rsp,
    output int         o_fail_count,
    output int         o_pending
);
    localparam int NLIST = (NEIGH < N_SUB) ? NEIGH : N_SUB;

    typedef struct packed {
        logic [OP_W-1:0]  done_op;
        logic [CNT_W-1:0] replaced_count;
        logic [OBJ_W-1:0] ref_nodes;
        logic [OBJ_W-1:0] ref_energy;
        logic [OBJ_W-1:0] read_nodes;
        logic [OBJ_W-1:0] read_energy;
        logic [TAG_W-1:0] read_tag;
    } t_rsp;

    logic [OBJ_W-1:0]   store_nodes  [N_SUB];
    logic [OBJ_W-1:0]   store_energy [N_SUB];
    logic [TAG_W-1:0]   store_tag    [N_SUB];
    logic [OBJ_W-1:0]   ideal_nodes;
    logic [OBJ_W-1:0]   ideal_energy;
    logic [WGT_W-1:0]   wgt_nodes    [N_SUB];
    logic [WGT_W-1:0]   wgt_energy   [N_SUB];
    int                 neigh_list   [N_SUB][NLIST];
    t_rsp               expected_rsp [$];

    initial begin
        int gap [N_SUB];
        int order [N_SUB];
        int t;
        for (int i = 0; i < N_SUB; i++) begin
            wgt_nodes[i]  = WGT_W'((64'(i) << 16) / (N_SUB - 1));
            wgt_energy[i] = WGT_W'((64'(N_SUB - 1 - i) << 16) / (N_SUB - 1));
            if (wgt_nodes[i] == 0) wgt_nodes[i] = 1;
            if (wgt_energy[i] == 0) wgt_energy[i] = 1;
            for (int j = 0; j < N_SUB; j++) begin
                gap[j]   = (i >= j) ? i - j : j - i;
                order[j] = j;
            end
            for (int a = 0; a < NLIST; a++) begin
                for (int b = a + 1; b < N_SUB; b++) begin
                    if (gap[a] > gap[b]) begin
                        t = gap[a];   gap[a]   = gap[b];   gap[b]   = t;
                        t = order[a]; order[a] = order[b]; order[b] = t;
                    end
                end
            end
            for (int a = 0; a < NLIST; a++) neigh_list[i][a] = order[a];
        end
    end

    function automatic logic [63:0] tcheby(logic [OBJ_W-1:0] yn, logic [OBJ_W-1:0] ye,
                                           int k);
        logic [63:0] dn, de;
        dn = (yn >= ideal_nodes) ? 64'(yn - ideal_nodes) : 64'(ideal_nodes - yn);
        de = (ye >= ideal_energy) ? 64'(ye - ideal_energy) : 64'(ideal_energy - ye);
        dn = dn * 64'(wgt_nodes[k]);
        de = de * 64'(wgt_energy[k]);
        return (dn > de) ? dn : de;
    endfunction

    function automatic t_rsp apply_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] ix,
                                           logic [OBJ_W-1:0] yn, logic [OBJ_W-1:0] ye,
                                           logic [TAG_W-1:0] tag);
        t_rsp r;
        int   k;
        r = '0;
        r.done_op = op;
        if (op == OP_WRITE) begin
            if (ix < N_SUB) begin
                store_nodes[ix] = yn; store_energy[ix] = ye; store_tag[ix] = tag;
            end
        end else if (op == OP_OFFER) begin
            if (yn < ideal_nodes) ideal_nodes = yn;
            if (ye < ideal_energy) ideal_energy = ye;
            if (ix < N_SUB) begin
                for (int a = 0; a < NLIST; a++) begin
                    k = neigh_list[ix][a];
                    if (tcheby(yn, ye, k) < tcheby(store_nodes[k], store_energy[k], k)) begin
                        store_nodes[k] = yn; store_energy[k] = ye; store_tag[k] = tag;
                        if (r.replaced_count != 3'd7) r.replaced_count++;
                    end
                end
            end
        end else if (op == OP_READ) begin
            if (ix < N_SUB) begin
                r.read_nodes  = store_nodes[ix];
                r.read_energy = store_energy[ix];
                r.read_tag    = store_tag[ix];
            end
        end
        r.ref_nodes  = ideal_nodes;
        r.ref_energy = ideal_energy;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_rsp got, exp_r;
        if (!i_rst_n) begin
            ideal_nodes  <= '1;
            ideal_energy <= '1;
            expected_rsp.delete();
            o_fail_count <= 0;
        end else begin
            if (i_req.valid && i_req.ready)
                expected_rsp = {expected_rsp,
                                apply_request(i_req.op, i_req.index, i_req.obj_nodes,
                                              i_req.obj_energy, i_req.solution_tag)};
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{i_rsp.done_op, i_rsp.replaced_count, i_rsp.ref_nodes,
                        i_rsp.ref_energy, i_rsp.read_nodes, i_rsp.read_energy,
                        i_rsp.read_tag};
                if (expected_rsp.size() == 0) begin
                    $display("%0t: unexpected response %p", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_rsp.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: response mismatch expected %p actual %p",
                                 $time, exp_r, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

    assign o_pending = expected_rsp.size();
endmodule

### dv/tb_top.sv
// top of the neighbourhood update testbench: clock, reset, stimulus, verdict
`timescale 1ns / 1ps
module tb_top;
    import tnu_pkg::*;

    localparam int NUM_RANDOM  = 1700;
    localparam int STALL_LIMIT = 5000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   src_idle;
    int   dst_idle;
    int   quiet_cycles;

    tnu_in_if  req ();
    tnu_out_if rsp ();

    tchebycheff_neighbour_update dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req.sink),
        .o_rsp   (rsp.source)
    );

    tnu_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_rsp        (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        rsp.ready <= ($urandom_range(99) >= dst_idle);
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] ix,
                                logic [OBJ_W-1:0] yn, logic [OBJ_W-1:0] ye,
                                logic [TAG_W-1:0] tag);
        while ($urandom_range(99) < src_idle) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid        <= 1'b1;
        req.op           <= op;
        req.index        <= ix;
        req.obj_nodes    <= yn;
        req.obj_energy   <= ye;
        req.solution_tag <= tag;
        do @(posedge i_clk); while (!req.ready);
    endtask

    function automatic logic [OBJ_W-1:0] rand_obj();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom >> $urandom_range(31);
            2: return {8'($urandom_range(255)), 24'($urandom)};
            default: return $urandom_range(4095);
        endcase
    endfunction

    initial begin
        logic [OP_W-1:0] op;
        int              pick;
        i_rst_n          = 1'b0;
        req.valid        = 1'b0;
        req.op           = OP_WRITE;
        req.index        = '0;
        req.obj_nodes    = '0;
        req.obj_energy   = '0;
        req.solution_tag = '0;
        src_idle         = 9;
        dst_idle         = 71;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every entry gets written before it can be read or scored
        for (int i = 0; i < N_SUB_DEF; i++)
            send_request(OP_WRITE, IDX_W'(i), $urandom, $urandom, $urandom);

        send_request(OP_READ,  6'd0,  '0, '0, '0);
        send_request(OP_READ,  6'd63, '0, '0, '0);
        send_request(OP_OFFER, 6'd0,  '1, '1, 32'hffff_ffff);
        send_request(OP_OFFER, 6'd63, 32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678);
        send_request(OP_WRITE, 6'd63, '1, '1, '1);
        send_request(OP_WRITE, 6'd0,  '0, '0, '0);
        send_request(OP_READ,  6'd63, '0, '0, '0);
        send_request(OP_READ,  6'd0,  '0, '0, '0);
        send_request(OP_OFFER, 6'd31, 32'h0001_0000, 32'h0002_0000, 32'h0000_0031);
        send_request(OP_OFFER, 6'd1,  32'h0000_0001, 32'hffff_fffe, 32'h0000_0001);
        send_request(OP_OFFER, 6'd62, 32'hffff_fffe, 32'h0000_0001, 32'h0000_0062);
        send_request(OP_OFFER, 6'd0,  '0, '0, 32'hdead_beef);
        send_request(OP_OFFER, 6'd63, '0, '0, 32'hcafe_f00d);
        send_request(OP_READ,  6'd60, '0, '0, '0);
        send_request(OP_READ,  6'd3,  '0, '0, '0);
        send_request(OP_OFFER, 6'd32, '1, '1, 32'h0);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM / 3) begin
                src_idle = 71;
                dst_idle = 9;
            end else if (n == 2 * NUM_RANDOM / 3) begin
                src_idle = 0;
                dst_idle = 0;
            end
            pick = $urandom_range(99);
            op = (pick < 50) ? OP_OFFER : (pick < 75) ? OP_WRITE : OP_READ;
            send_request(op, IDX_W'($urandom), rand_obj(), rand_obj(), $urandom);
        end
        req.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

### files.f
+incdir+design
design/tnu_pkg.sv
design/tnu_if.sv
design/tnu_ram.sv
design/tnu_tables.sv
design/tchebycheff_neighbour_update.sv
design/tnu_checker.sv
dv/tnu_checker.sv
dv/tb_top.sv
